/* rtl/lir_pkg.sv */
// Shared types and constants for the linear interpolation resampler.
`timescale 1ns / 1ps

package lir_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int CH_W         = 3;
    localparam int CNT_W        = 4;
    localparam int STEP_RAW_W   = 20;
    localparam int SKIP_W       = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 20;
    localparam int STEP_SRC_FRAC = 16;

    localparam logic [STEP_RAW_W-1:0] STEP_MIN   = 20'd8192;
    localparam logic [STEP_RAW_W-1:0] STEP_RESET = 20'd65536;
    localparam logic [CNT_W-1:0]      COUNT_RESET = 4'd1;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_RATIO    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;

    typedef struct packed {
        logic accept;
        logic calc;
        logic load;
    } lir_cmd_t;

    typedef struct packed {
        logic emit;
        logic last_ch;
        logic frame_done;
        logic out_free;
    } lir_status_t;

endpackage

/* rtl/lir_datapath.sv */
// Frame storage, phase accumulator, interpolator and output register.
`timescale 1ns / 1ps

module lir_datapath #(
    parameter int MAX_CHANNELS    = 8,
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [lir_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lir_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [lir_pkg::SAMPLE_W-1:0]         s_tdata,
    input  logic                                 s_tlast,
    output logic [lir_pkg::SAMPLE_W-1:0]         m_tdata,
    output logic [lir_pkg::CH_W-1:0]             m_tuser,
    output logic                                 m_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  lir_pkg::lir_cmd_t                    cmd,
    output lir_pkg::lir_status_t                 sts
);

    localparam int F      = PHASE_FRAC_BITS;
    localparam int IDX_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int STEP_W = F + 4;
    localparam int PSUM_W = F + 5;
    localparam int DIFF_W = lir_pkg::SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + F + 1;
    localparam int NUM_W  = F + lir_pkg::SAMPLE_W + 3;
    localparam int SHL    = (F >= lir_pkg::STEP_SRC_FRAC) ? F - lir_pkg::STEP_SRC_FRAC : 0;
    localparam int SHR    = (F <  lir_pkg::STEP_SRC_FRAC) ? lir_pkg::STEP_SRC_FRAC - F : 0;

    logic [lir_pkg::STEP_RAW_W-1:0]     step_reg;
    logic [lir_pkg::CNT_W-1:0]          count_reg;
    logic signed [lir_pkg::SAMPLE_W-1:0] prev_reg [MAX_CHANNELS];
    logic signed [lir_pkg::SAMPLE_W-1:0] cur_reg  [MAX_CHANNELS];
    logic signed [lir_pkg::SAMPLE_W-1:0] merged   [MAX_CHANNELS];
    logic [lir_pkg::CH_W-1:0]           chpos_reg;
    logic [F-1:0]                       phase_reg;
    logic [lir_pkg::SKIP_W-1:0]         skip_reg;
    logic                               have_prev_reg;
    logic [F-1:0]                       p_reg;
    logic [lir_pkg::CH_W-1:0]           ch_reg;
    logic                               eob_reg;
    logic signed [PROD_W-1:0]           prod_reg;
    logic signed [lir_pkg::SAMPLE_W-1:0] a_reg;
    logic [lir_pkg::SAMPLE_W-1:0]       out_data_reg;
    logic [lir_pkg::CH_W-1:0]           out_ch_reg;
    logic                               out_last_reg;
    logic                               out_valid_reg;

    logic [lir_pkg::CNT_W-1:0]          n_act;
    logic [lir_pkg::CH_W-1:0]           n_last;
    logic [lir_pkg::CH_W-1:0]           pos;
    logic [IDX_W-1:0]                   pos_idx;
    logic [IDX_W-1:0]                   ch_idx;
    logic                               completes;
    logic [lir_pkg::STEP_RAW_W-1:0]     step_q16;
    logic [STEP_W-1:0]                  step_eff;
    logic [PSUM_W-1:0]                  p_sum;
    logic [lir_pkg::SKIP_W:0]           k_int;
    logic signed [DIFF_W-1:0]           diff;
    logic signed [NUM_W-1:0]            num;
    logic signed [NUM_W-1:0]            num_shr;
    logic                               round_up;
    logic [lir_pkg::SAMPLE_W-1:0]       result;

    always_comb begin
        if (count_reg == '0) begin
            n_act = lir_pkg::CNT_W'(1);
        end else if (count_reg > lir_pkg::CNT_W'(MAX_CHANNELS)) begin
            n_act = lir_pkg::CNT_W'(MAX_CHANNELS);
        end else begin
            n_act = count_reg;
        end
        n_last    = lir_pkg::CH_W'(n_act - lir_pkg::CNT_W'(1));
        pos       = ({1'b0, chpos_reg} >= n_act) ? n_last : chpos_reg;
        pos_idx   = pos[IDX_W-1:0];
        ch_idx    = ch_reg[IDX_W-1:0];
        completes = (pos == n_last);
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            merged[i] = (IDX_W'(i) == pos_idx) ? s_tdata : cur_reg[i];
        end
    end

    always_comb begin
        step_q16 = (step_reg < lir_pkg::STEP_MIN) ? lir_pkg::STEP_MIN : step_reg;
        if (F >= lir_pkg::STEP_SRC_FRAC) begin
            step_eff = STEP_W'(step_q16) << SHL;
        end else begin
            step_eff = STEP_W'(step_q16 >> SHR);
        end
        p_sum = {5'b0, p_reg} + {1'b0, step_eff};
        k_int = p_sum[PSUM_W-1:F];
    end

    always_comb begin
        diff     = DIFF_W'(cur_reg[ch_idx]) - DIFF_W'(prev_reg[ch_idx]);
        num      = (NUM_W'(a_reg) <<< F) + NUM_W'(prod_reg);
        num_shr  = num >>> F;
        round_up = num[NUM_W-1] && (num[F-1:0] != '0);
        result   = lir_pkg::SAMPLE_W'(num_shr + NUM_W'(round_up));
    end

    always_comb begin
        sts.emit       = completes && have_prev_reg && (skip_reg == '0);
        sts.last_ch    = (ch_reg == n_last);
        sts.frame_done = (k_int != '0);
        sts.out_free   = !out_valid_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= lir_pkg::STEP_RESET;
            count_reg     <= lir_pkg::COUNT_RESET;
            chpos_reg     <= '0;
            phase_reg     <= '0;
            skip_reg      <= '0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            eob_reg       <= 1'b0;
            ch_reg        <= '0;
            p_reg         <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                prev_reg[i] <= '0;
                cur_reg[i]  <= '0;
            end
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    lir_pkg::REG_STEP_RATIO: begin
                        step_reg <= cfg_data;
                    end
                    lir_pkg::REG_CHANNEL_COUNT: begin
                        count_reg <= cfg_data[lir_pkg::CNT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (cmd.load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.accept) begin
                if (s_tlast && !sts.emit) begin
                    chpos_reg     <= '0;
                    phase_reg     <= '0;
                    skip_reg      <= '0;
                    have_prev_reg <= 1'b0;
                    for (int i = 0; i < MAX_CHANNELS; i++) begin
                        prev_reg[i] <= '0;
                        cur_reg[i]  <= '0;
                    end
                end else begin
                    cur_reg[pos_idx] <= s_tdata;
                    if (!completes) begin
                        chpos_reg <= pos + lir_pkg::CH_W'(1);
                    end else begin
                        chpos_reg <= '0;
                        if (!have_prev_reg) begin
                            have_prev_reg <= 1'b1;
                            prev_reg      <= merged;
                        end else if (skip_reg != '0) begin
                            skip_reg <= skip_reg - lir_pkg::SKIP_W'(1);
                            prev_reg <= merged;
                        end else begin
                            p_reg   <= phase_reg;
                            ch_reg  <= '0;
                            eob_reg <= s_tlast;
                        end
                    end
                end
            end

            if (cmd.calc) begin
                prod_reg <= PROD_W'($signed({1'b0, p_reg}) * diff);
                a_reg    <= prev_reg[ch_idx];
            end

            if (cmd.load) begin
                out_data_reg  <= result;
                out_ch_reg    <= ch_reg;
                out_last_reg  <= sts.last_ch && sts.frame_done;
                if (!sts.last_ch) begin
                    ch_reg <= ch_reg + lir_pkg::CH_W'(1);
                end else if (!sts.frame_done) begin
                    p_reg  <= p_sum[F-1:0];
                    ch_reg <= '0;
                end else if (eob_reg) begin
                    chpos_reg     <= '0;
                    phase_reg     <= '0;
                    skip_reg      <= '0;
                    have_prev_reg <= 1'b0;
                    for (int i = 0; i < MAX_CHANNELS; i++) begin
                        prev_reg[i] <= '0;
                        cur_reg[i]  <= '0;
                    end
                end else begin
                    phase_reg <= p_sum[F-1:0];
                    skip_reg  <= lir_pkg::SKIP_W'(k_int - 5'd1);
                    prev_reg  <= cur_reg;
                end
            end
        end
    end

    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ch_reg;
    assign m_tlast  = out_last_reg;
    assign m_tvalid = out_valid_reg;

endmodule

/* rtl/lir_ctrl.sv */
// Sequencing state machine for input acceptance and output generation.
`timescale 1ns / 1ps

module lir_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  lir_pkg::lir_status_t  sts,
    output lir_pkg::lir_cmd_t     cmd
);

    typedef enum logic [1:0] {
        IDLE,
        CALC,
        LOAD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    always_comb begin
        cmd.accept = s_tvalid && ready_reg;
        cmd.calc   = (state_reg == CALC);
        cmd.load   = (state_reg == LOAD) && sts.out_free;
        state_next = state_reg;
        case (state_reg)
            IDLE: begin
                if (cmd.accept && sts.emit) begin
                    state_next = CALC;
                end
            end
            CALC: begin
                state_next = LOAD;
            end
            LOAD: begin
                if (cmd.load) begin
                    state_next = (sts.last_ch && sts.frame_done) ? IDLE : CALC;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == IDLE);
        end
    end

    assign s_tready = ready_reg;

`ifndef SYNTH
    a_load_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> sts.out_free)
        else $error("output register overwritten while full");

    a_calc_then_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == CALC) |=> (state_reg == LOAD))
        else $error("multiply stage not followed by load");

    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ready_reg |-> (state_reg == IDLE))
        else $error("input ready while generating outputs");

    a_no_accept_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.calc || cmd.load) |-> !cmd.accept)
        else $error("beat accepted during output generation");
`endif

endmodule

/* rtl/linear_interp_resampler.sv */
// Top level of the linear interpolation sample rate converter.
//
//  channel  ports               dir  contents
//  input    s_tvalid/s_tready   in   s_tdata: sample_in[15:0]; s_tlast: end_of_block
//  output   m_tvalid/m_tready   out  m_tdata: sample_out[15:0]; m_tuser: channel_index[2:0];
//                                    m_tlast: last_of_run
//  config   cfg_we              in   cfg_index: 0 step_ratio, 1 channel_count; cfg_data
//
// A beat that yields no output leaves s_tready high.
// Each output sample is a multiply step, then an add-and-round step into the output
// register; s_tready is low while a beat's R outputs are generated, R up to 64, and
// a full output register holds the load step until m_tready frees it.
// The output register frees input acceptance while the final sample waits on m_tready.
// Reset is synchronous on aresetn low.
`timescale 1ns / 1ps

module linear_interp_resampler #(
    parameter int MAX_CHANNELS    = 8,
    parameter int PHASE_FRAC_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [lir_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lir_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lir_pkg::SAMPLE_W-1:0]      s_tdata,   // sample_in[15:0]
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lir_pkg::SAMPLE_W-1:0]      m_tdata,   // sample_out[15:0]
    output logic [lir_pkg::CH_W-1:0]          m_tuser,   // channel_index[2:0]
    output logic                              m_tlast
);

    lir_pkg::lir_cmd_t    cmd;
    lir_pkg::lir_status_t sts;

    lir_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lir_datapath #(
        .MAX_CHANNELS    (MAX_CHANNELS),
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

/* test/tb_linear_interp_resampler.sv */
// Self-checking testbench for the linear interpolation resampler.
`timescale 1ns / 1ps

module tb_linear_interp_resampler;

    localparam int MAX_CH = 8;
    localparam int BLOCK_LATENCY = 140;
    localparam int DRAIN_LIMIT = 50000;
    localparam logic [31:0] ONE_Q16 = 32'h10000;
    localparam logic [lir_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [lir_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [lir_pkg::SAMPLE_W-1:0] pcm;
        logic [lir_pkg::CH_W-1:0]     chan;
        logic                         last;
    } out_beat_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_we;
    logic [lir_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lir_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [lir_pkg::SAMPLE_W-1:0]   s_tdata;   // sample_in[15:0]
    logic                           s_tlast;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [lir_pkg::SAMPLE_W-1:0]   m_tdata;   // sample_out[15:0]
    logic [lir_pkg::CH_W-1:0]       m_tuser;   // channel_index[2:0]
    logic                           m_tlast;

    logic signed [lir_pkg::SAMPLE_W-1:0] prev_frame [MAX_CH];
    logic signed [lir_pkg::SAMPLE_W-1:0] cur_frame [MAX_CH];
    logic [lir_pkg::CH_W-1:0]            ch_pos;
    logic [15:0]                         phase_acc;
    logic [lir_pkg::SKIP_W-1:0]          skip_left;
    logic                                have_prev;
    logic [lir_pkg::STEP_RAW_W-1:0]      step_cfg;
    logic [lir_pkg::CNT_W-1:0]           chan_cfg;

    out_beat_t due_samples[$];
    int        mismatch_count = 0;
    int        stall_mode;
    bit        sender_gaps;
    int        long_hold_len;
    int        burst_left;

    linear_interp_resampler DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic logic [lir_pkg::SAMPLE_W-1:0] lerp_q16(
            input logic signed [lir_pkg::SAMPLE_W-1:0] a,
            input logic signed [lir_pkg::SAMPLE_W-1:0] b,
            input logic [15:0] frac);
        longint num;
        num = longint'(a) * 65536 + longint'(frac) * (longint'(b) - longint'(a));
        return lir_pkg::SAMPLE_W'(num / 65536);
    endfunction

    function automatic void clear_frames();
        for (int c = 0; c < MAX_CH; c++) begin
            prev_frame[c] = '0;
            cur_frame[c] = '0;
        end
        ch_pos = '0;
        phase_acc = '0;
        skip_left = '0;
        have_prev = 1'b0;
    endfunction

    task automatic resample_beat(input logic [lir_pkg::SAMPLE_W-1:0] smp, input logic eob);
        logic [lir_pkg::CNT_W-1:0]      n;
        logic [lir_pkg::CH_W-1:0]       slot;
        logic [lir_pkg::STEP_RAW_W-1:0] inc;
        logic [31:0]                    acc;
        logic                           wrap;
        out_beat_t                      r;
        n = (chan_cfg == 4'd0) ? 4'd1 : (chan_cfg > MAX_CH) ? 4'(MAX_CH) : chan_cfg;
        slot = ({1'b0, ch_pos} >= n) ? 3'(n - 4'd1) : ch_pos;
        cur_frame[slot] = smp;
        if ({1'b0, slot} + 4'd1 >= n) begin
            ch_pos = '0;
            if (!have_prev) begin
                have_prev = 1'b1;
            end else if (skip_left != '0) begin
                skip_left = skip_left - 4'd1;
            end else begin
                inc = (step_cfg < lir_pkg::STEP_MIN) ? lir_pkg::STEP_MIN : step_cfg;
                acc = {16'd0, phase_acc};
                do begin
                    wrap = (acc + {12'd0, inc}) >= ONE_Q16;
                    for (int c = 0; c < int'(n); c++) begin
                        r.pcm = lerp_q16(prev_frame[c], cur_frame[c], acc[15:0]);
                        r.chan = 3'(c);
                        r.last = wrap && (c == int'(n) - 1);
                        due_samples.push_back(r);
                    end
                    acc = acc + {12'd0, inc};
                end while (!wrap);
                phase_acc = acc[15:0];
                skip_left = 4'(acc[31:16] - 16'd1);
            end
            for (int c = 0; c < MAX_CH; c++) prev_frame[c] = cur_frame[c];
        end else begin
            ch_pos = slot + 3'd1;
        end
        if (eob) clear_frames();
    endtask

    task automatic write_reg(input logic [lir_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lir_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            lir_pkg::REG_STEP_RATIO:    step_cfg = val[lir_pkg::STEP_RAW_W-1:0];
            lir_pkg::REG_CHANNEL_COUNT: chan_cfg = val[lir_pkg::CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_beat(input logic [lir_pkg::SAMPLE_W-1:0] smp, input logic eob);
        int gap;
        gap = 0;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            if (sender_gaps) gap = $urandom_range(1, 8);
        end
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= smp;
        s_tlast <= eob;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        resample_beat(smp, eob);
        burst_left--;
    endtask

    task automatic wait_idle();
        int waited;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
        waited = 0;
        while (due_samples.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (BLOCK_LATENCY) @(posedge aclk);
    endtask

    function automatic logic [lir_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge aclk) begin : check_out
        out_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_samples.size() == 0) begin
                report_mismatch($sformatf("unexpected output beat pcm=%h ch=%0d last=%b",
                                          m_tdata, m_tuser, m_tlast));
            end else begin
                want = due_samples.pop_front();
                if (m_tdata !== want.pcm)
                    report_mismatch($sformatf("sample_out got %h want %h", m_tdata, want.pcm));
                if (m_tuser !== want.chan)
                    report_mismatch($sformatf("channel_index got %0d want %0d",
                                              m_tuser, want.chan));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last_of_run got %b want %b", m_tlast, want.last));
            end
        end
    end

    initial begin : receiver
        int hold_cnt;
        int rx_cycle;
        hold_cnt = 0;
        rx_cycle = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            rx_cycle++;
            if (long_hold_len != 0) begin
                hold_cnt = long_hold_len;
                long_hold_len = 0;
            end
            if (hold_cnt != 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else begin
                case (stall_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= ((rx_cycle % 7) >= 3);
                    default: m_tready <= ($urandom_range(0, 9) < 4);
                endcase
            end
        end
    end

    task automatic test_reset_values();
        send_beat(16'h7FFF, 1'b0);
        send_beat(16'h8000, 1'b0);
        send_beat(16'h0000, 1'b0);
    endtask

    task automatic test_fraction_steps();
        wait_idle();
        write_reg(lir_pkg::REG_STEP_RATIO, 20'h04000);
        send_beat(16'h8000, 1'b0);
        send_beat(16'h7FFF, 1'b0);
        send_beat(16'h8001, 1'b0);
    endtask

    task automatic test_step_floor();
        wait_idle();
        write_reg(lir_pkg::REG_STEP_RATIO, 20'd100);
        send_beat(16'hFFFF, 1'b0);
        send_beat(16'h8000, 1'b0);
        wait_idle();
        write_reg(lir_pkg::REG_STEP_RATIO, 20'd0);
        send_beat(16'h7FFF, 1'b0);
    endtask

    task automatic test_skip_frames();
        wait_idle();
        write_reg(lir_pkg::REG_STEP_RATIO, 20'hFFFFF);
        send_beat(16'h1234, 1'b0);
        send_beat(16'h4321, 1'b0);
        send_beat(16'hABCD, 1'b1);
    endtask

    task automatic test_channel_limits();
        wait_idle();
        write_reg(lir_pkg::REG_STEP_RATIO, 20'h10000);
        write_reg(lir_pkg::REG_CHANNEL_COUNT, 20'd0);
        send_beat(16'h0001, 1'b0);
        send_beat(16'hFFFE, 1'b0);
        wait_idle();
        write_reg(lir_pkg::REG_CHANNEL_COUNT, 20'd15);
        send_beat(16'h5555, 1'b0);
        send_beat(16'hAAAA, 1'b1);
    endtask

    task automatic test_count_lowered();
        wait_idle();
        write_reg(lir_pkg::REG_STEP_RATIO, 20'h08000);
        write_reg(lir_pkg::REG_CHANNEL_COUNT, 20'd3);
        send_beat(16'h1000, 1'b0);
        send_beat(16'hF000, 1'b0);
        wait_idle();
        write_reg(lir_pkg::REG_CHANNEL_COUNT, 20'd2);
        send_beat(16'h7000, 1'b0);
    endtask

    task automatic test_end_of_block();
        send_beat(16'h7FFF, 1'b1);
        send_beat(16'h8000, 1'b0);
        send_beat(16'h7FFF, 1'b0);
        send_beat(16'h7FFF, 1'b0);
        send_beat(16'h8000, 1'b1);
    endtask

    task automatic test_spare_index();
        wait_idle();
        write_reg(REG_SPARE_2, '1);
        write_reg(REG_SPARE_3, '1);
        send_beat(16'h0F0F, 1'b0);
        send_beat(16'hF0F0, 1'b0);
    endtask

    task automatic test_output_backpressure();
        wait_idle();
        write_reg(lir_pkg::REG_CHANNEL_COUNT, 20'd2);
        write_reg(lir_pkg::REG_STEP_RATIO, 20'h08000);
        stall_mode = 1;
        sender_gaps = 1'b0;
        long_hold_len = 300;
        for (int i = 0; i < 12; i++) send_beat(pick_sample(), 1'b0);
    endtask

    task automatic test_random_stream();
        logic [lir_pkg::STEP_RAW_W-1:0] step;
        logic [lir_pkg::CNT_W-1:0]      count;
        for (int p = 0; p < 8; p++) begin
            wait_idle();
            case (p)
                0: begin
                    count = 4'd8;
                    step = 20'd0;
                end
                1: begin
                    count = 4'd1;
                    step = 20'hFFFFF;
                end
                default: begin
                    count = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                        : 4'($urandom_range(1, 8));
                    case ($urandom_range(0, 3))
                        0:       step = 20'($urandom_range(8192, 32768));
                        1:       step = 20'($urandom_range(32768, 196608));
                        2:       step = 20'($urandom_range(0, 8191));
                        default: step = 20'($urandom);
                    endcase
                end
            endcase
            write_reg(lir_pkg::REG_CHANNEL_COUNT, {16'd0, count});
            write_reg(lir_pkg::REG_STEP_RATIO, step);
            stall_mode = (p == 0) ? 0 : $urandom_range(0, 3);
            sender_gaps = (p == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            for (int i = 0; i < 28; i++)
                send_beat(pick_sample(), $urandom_range(0, 39) == 0);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        stall_mode = 1;
        sender_gaps = 1'b1;
        long_hold_len = 0;
        burst_left = 0;
        step_cfg = lir_pkg::STEP_RESET;
        chan_cfg = lir_pkg::COUNT_RESET;
        clear_frames();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_values();
        test_fraction_steps();
        test_step_floor();
        test_skip_frames();
        test_channel_limits();
        test_count_lowered();
        test_end_of_block();
        test_spare_index();
        test_output_backpressure();
        test_random_stream();

        wait_idle();
        if (due_samples.size() != 0)
            report_mismatch($sformatf("%0d output beats never arrived", due_samples.size()));
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* files.f */
rtl/lir_pkg.sv
rtl/lir_datapath.sv
rtl/lir_ctrl.sv
rtl/linear_interp_resampler.sv
test/tb_linear_interp_resampler.sv
